// ===== src/ufd_pkg.sv =====
`timescale 1ns / 1ps

package ufd_pkg;

   // item codes on the request side
   typedef enum logic [1:0] {
      CMD_ARM  = 2'd0,
      CMD_BYTE = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_SYNC_TIMEOUT   = 3'd1,
      ST_CMD_TIMEOUT    = 3'd2,
      ST_LEN_TIMEOUT    = 3'd3,
      ST_TOO_LONG       = 3'd4,
      ST_PAY_TIMEOUT    = 3'd5,
      ST_FOOTER_TIMEOUT = 3'd6,
      ST_BAD_FOOTER     = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_SYNC0 = 4'd1,
      PH_SYNC1 = 4'd2,
      PH_CMD   = 4'd3,
      PH_LEN   = 4'd4,
      PH_PAY   = 4'd5,
      PH_FOOT0 = 4'd6,
      PH_FOOT1 = 4'd7
   } phase_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_SYNC_TIMEOUT = 3'd0,
      REG_BYTE_TIMEOUT = 3'd1,
      REG_PAY_TIMEOUT  = 3'd2,
      REG_MAX_LEN      = 3'd3,
      REG_MIN_IMAGE    = 3'd4,
      REG_IMAGE_CMD    = 3'd5,
      REG_SPARE6       = 3'd6,
      REG_SPARE7       = 3'd7
   } reg_index_type;

   localparam int unsigned CSR_DATA_WIDTH = 24;

   localparam logic [7:0] SYNC_FIRST   = 8'hAA;
   localparam logic [7:0] SYNC_SECOND  = 8'h55;
   localparam logic [7:0] FOOTER_FIRST = 8'h0D;
   localparam logic [7:0] FOOTER_LAST  = 8'h0A;
   localparam logic [15:0] IMAGE_SOI   = 16'hFFD8;
   localparam logic [15:0] IMAGE_EOI   = 16'hFFD9;

   localparam logic [19:0] SYNC_TIMEOUT_RESET = 20'd3000;
   localparam logic [19:0] BYTE_TIMEOUT_RESET = 20'd1000;
   localparam logic [19:0] PAY_TIMEOUT_RESET  = 20'd200000;
   localparam logic [23:0] MAX_LEN_RESET      = 24'(200 * 1024);
   localparam logic [23:0] MIN_IMAGE_RESET    = 24'd100;
   localparam logic [7:0]  IMAGE_CMD_RESET    = 8'd2;

   typedef struct packed {
      logic [19:0] sync_timeout_ms;
      logic [19:0] byte_timeout_ms;
      logic [19:0] payload_idle_timeout_ms;
      logic [23:0] max_payload_len;
      logic [23:0] min_image_len;
      logic [7:0]  image_command;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        last;
      logic [7:0]  frame_command;
      logic [23:0] frame_length;
      logic [2:0]  status;
      logic        image_valid;
   } rsp_payload_type;

endpackage

// ===== src/ufd_csr.sv =====
`timescale 1ns / 1ps

module ufd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [2:0]                          csr_index,
   input  logic [ufd_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output ufd_pkg::cfg_type                    cfg
);

   ufd_pkg::cfg_type cfg_ff;
   ufd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (ufd_pkg::reg_index_type'(csr_index))
            ufd_pkg::REG_SYNC_TIMEOUT: cfg_in.sync_timeout_ms = csr_wr_data[19:0];
            ufd_pkg::REG_BYTE_TIMEOUT: cfg_in.byte_timeout_ms = csr_wr_data[19:0];
            ufd_pkg::REG_PAY_TIMEOUT:  cfg_in.payload_idle_timeout_ms = csr_wr_data[19:0];
            ufd_pkg::REG_MAX_LEN:      cfg_in.max_payload_len = csr_wr_data[23:0];
            ufd_pkg::REG_MIN_IMAGE:    cfg_in.min_image_len = csr_wr_data[23:0];
            ufd_pkg::REG_IMAGE_CMD:    cfg_in.image_command = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_timeout_ms         <= ufd_pkg::SYNC_TIMEOUT_RESET;
         cfg_ff.byte_timeout_ms         <= ufd_pkg::BYTE_TIMEOUT_RESET;
         cfg_ff.payload_idle_timeout_ms <= ufd_pkg::PAY_TIMEOUT_RESET;
         cfg_ff.max_payload_len         <= ufd_pkg::MAX_LEN_RESET;
         cfg_ff.min_image_len           <= ufd_pkg::MIN_IMAGE_RESET;
         cfg_ff.image_command           <= ufd_pkg::IMAGE_CMD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ufd_engine.sv =====
`timescale 1ns / 1ps

module ufd_engine #(
   parameter int unsigned COUNT_WIDTH = 24,
   parameter int unsigned TIMER_WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  ufd_pkg::req_payload_type item,
   input  ufd_pkg::cfg_type         cfg,
   output logic                     res_valid,
   output ufd_pkg::rsp_payload_type res
);

   localparam int unsigned LimWidth = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;
   localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;
   localparam logic [LimWidth-1:0] TimerMax = LimWidth'({TIMER_WIDTH{1'b1}});

   ufd_pkg::phase_type      phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]  stage_timer_ff, stage_timer_in;
   logic [31:0]             length_raw_ff, length_raw_in;
   logic [1:0]              len_index_ff, len_index_in;
   logic [COUNT_WIDTH-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]              held_command_ff, held_command_in;
   logic [15:0]             first_two_ff, first_two_in;
   logic [15:0]             last_two_ff, last_two_in;
   logic [7:0]              footer_first_ff, footer_first_in;

   logic [TIMER_WIDTH-1:0]  timer_inc;
   logic [LimWidth-1:0]     limit_raw;
   logic [LimWidth-1:0]     limit_clip;
   ufd_pkg::status_type     tick_status;
   logic                    tick_active;
   logic [31:0]             length_new;
   logic [COUNT_WIDTH-1:0]  count_inc;
   logic                    pay_last;
   logic                    image_ok;
   ufd_pkg::kind_type       res_kind;
   logic [7:0]              res_data;
   logic                    res_last;
   ufd_pkg::status_type     res_status;
   logic                    res_image;
   logic [7:0]              b;

   assign b = item.rx_byte;

   // saturating tick count and per-stage limit
   assign timer_inc = (&stage_timer_ff) ? stage_timer_ff : stage_timer_ff + 1'b1;

   always_comb begin
      tick_active = 1'b1;
      limit_raw   = LimWidth'(cfg.byte_timeout_ms);
      tick_status = ufd_pkg::ST_CMD_TIMEOUT;
      case (phase_ff)
         ufd_pkg::PH_SYNC0, ufd_pkg::PH_SYNC1: begin
            limit_raw   = LimWidth'(cfg.sync_timeout_ms);
            tick_status = ufd_pkg::ST_SYNC_TIMEOUT;
         end
         ufd_pkg::PH_CMD: tick_status = ufd_pkg::ST_CMD_TIMEOUT;
         ufd_pkg::PH_LEN: tick_status = ufd_pkg::ST_LEN_TIMEOUT;
         ufd_pkg::PH_PAY: begin
            limit_raw   = LimWidth'(cfg.payload_idle_timeout_ms);
            tick_status = ufd_pkg::ST_PAY_TIMEOUT;
         end
         ufd_pkg::PH_FOOT0, ufd_pkg::PH_FOOT1: tick_status = ufd_pkg::ST_FOOTER_TIMEOUT;
         default: tick_active = 1'b0;
      endcase
      limit_clip = (limit_raw > TimerMax) ? TimerMax : limit_raw;
   end

   assign length_new = length_raw_ff | (32'(b) << {len_index_ff, 3'b000});
   assign count_inc  = byte_count_ff + 1'b1;
   assign pay_last   = 33'(count_inc) >= {1'b0, length_raw_ff};

   assign image_ok = (held_command_ff == cfg.image_command)
                  && (length_raw_ff >= 32'(cfg.min_image_len))
                  && (length_raw_ff >= 32'd2)
                  && (first_two_ff == ufd_pkg::IMAGE_SOI)
                  && (last_two_ff == ufd_pkg::IMAGE_EOI);

   always_comb begin
      phase_in        = phase_ff;
      stage_timer_in  = stage_timer_ff;
      length_raw_in   = length_raw_ff;
      len_index_in    = len_index_ff;
      byte_count_in   = byte_count_ff;
      held_command_in = held_command_ff;
      first_two_in    = first_two_ff;
      last_two_in     = last_two_ff;
      footer_first_in = footer_first_ff;
      res_valid       = 1'b0;
      res_kind        = ufd_pkg::KIND_ERROR;
      res_data        = 8'd0;
      res_last        = 1'b0;
      res_status      = ufd_pkg::ST_OK;
      res_image       = 1'b0;
      if (fire) begin
         unique case (ufd_pkg::cmd_type'(item.cmd))
            ufd_pkg::CMD_ARM: begin
               phase_in        = ufd_pkg::PH_SYNC0;
               stage_timer_in  = '0;
               length_raw_in   = '0;
               len_index_in    = '0;
               byte_count_in   = '0;
               held_command_in = '0;
               first_two_in    = '0;
               last_two_in     = '0;
               footer_first_in = '0;
            end
            ufd_pkg::CMD_TICK: begin
               if (tick_active) begin
                  if (LimWidth'(timer_inc) >= limit_clip) begin
                     res_valid      = 1'b1;
                     res_status     = tick_status;
                     phase_in       = ufd_pkg::PH_IDLE;
                     stage_timer_in = '0;
                  end else begin
                     stage_timer_in = timer_inc;
                  end
               end
            end
            ufd_pkg::CMD_BYTE: begin
               case (phase_ff)
                  ufd_pkg::PH_SYNC0: begin
                     if (b == ufd_pkg::SYNC_FIRST) phase_in = ufd_pkg::PH_SYNC1;
                  end
                  ufd_pkg::PH_SYNC1: begin
                     // a repeated first sync byte keeps the hunt armed
                     if (b == ufd_pkg::SYNC_SECOND) begin
                        phase_in       = ufd_pkg::PH_CMD;
                        stage_timer_in = '0;
                     end else if (b != ufd_pkg::SYNC_FIRST) begin
                        phase_in = ufd_pkg::PH_SYNC0;
                     end
                  end
                  ufd_pkg::PH_CMD: begin
                     held_command_in = b;
                     length_raw_in   = '0;
                     len_index_in    = '0;
                     phase_in        = ufd_pkg::PH_LEN;
                     stage_timer_in  = '0;
                  end
                  ufd_pkg::PH_LEN: begin
                     length_raw_in = length_new;
                     if (len_index_ff != 2'd3) begin
                        len_index_in = len_index_ff + 1'b1;
                     end else begin
                        len_index_in = '0;
                        if ((length_new > 32'(cfg.max_payload_len))
                            || ({1'b0, length_new} > CountMax)) begin
                           res_valid      = 1'b1;
                           res_status     = ufd_pkg::ST_TOO_LONG;
                           phase_in       = ufd_pkg::PH_IDLE;
                           stage_timer_in = '0;
                        end else begin
                           byte_count_in  = '0;
                           stage_timer_in = '0;
                           phase_in = (length_new == 32'd0) ? ufd_pkg::PH_FOOT0
                                                            : ufd_pkg::PH_PAY;
                        end
                     end
                  end
                  ufd_pkg::PH_PAY: begin
                     if (byte_count_ff < COUNT_WIDTH'(2)) first_two_in = {first_two_ff[7:0], b};
                     last_two_in    = {last_two_ff[7:0], b};
                     byte_count_in  = count_inc;
                     stage_timer_in = '0;
                     res_valid      = 1'b1;
                     res_kind       = ufd_pkg::KIND_PAYLOAD;
                     res_data       = b;
                     res_last       = pay_last;
                     if (pay_last) phase_in = ufd_pkg::PH_FOOT0;
                  end
                  ufd_pkg::PH_FOOT0: begin
                     footer_first_in = b;
                     phase_in        = ufd_pkg::PH_FOOT1;
                  end
                  ufd_pkg::PH_FOOT1: begin
                     res_valid      = 1'b1;
                     phase_in       = ufd_pkg::PH_IDLE;
                     stage_timer_in = '0;
                     if ((footer_first_ff != ufd_pkg::FOOTER_FIRST)
                         || (b != ufd_pkg::FOOTER_LAST)) begin
                        res_status = ufd_pkg::ST_BAD_FOOTER;
                     end else begin
                        res_kind  = ufd_pkg::KIND_COMPLETE;
                        res_image = image_ok;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      res.kind          = res_kind;
      res.data          = res_data;
      res.last          = res_last;
      res.frame_command = held_command_in;
      res.frame_length  = (|length_raw_in[31:24]) ? 24'hFFFFFF : length_raw_in[23:0];
      res.status        = res_status;
      res.image_valid   = res_image;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ufd_pkg::PH_IDLE;
         stage_timer_ff  <= '0;
         length_raw_ff   <= '0;
         len_index_ff    <= '0;
         byte_count_ff   <= '0;
         held_command_ff <= '0;
         first_two_ff    <= '0;
         last_two_ff     <= '0;
         footer_first_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         stage_timer_ff  <= stage_timer_in;
         length_raw_ff   <= length_raw_in;
         len_index_ff    <= len_index_in;
         byte_count_ff   <= byte_count_in;
         held_command_ff <= held_command_in;
         first_two_ff    <= first_two_in;
         last_two_ff     <= last_two_in;
         footer_first_ff <= footer_first_in;
      end
   end

endmodule

// ===== src/uart_frame_deframer.sv =====
`timescale 1ns / 1ps
// receive deframer for a byte link with sync, command, length, payload and footer
// req channel: one beat per item (arm, received byte or 1 ms tick), req_valid/req_stall
// rsp channel: at most one beat per item: a payload byte with last mark, a frame
//   completion with command, length and image check, or an error with its status
// csr port: csr_wr_en writes csr_wr_data into the register picked by csr_index;
//   write only while no frame is in flight and no result is pending
// path: a request beat is taken into the input register; the frame state machine updates
//   combinationally and its result is registered into the output register that drives rsp
// throughput: one item per cycle unless rsp_stall holds a full output register
// stall: rsp_stall holds the output register; the input register takes at most one
//   more beat, then req_stall rises until the output register drains
// reset: synchronous, returns to idle with registers at their defaults; bytes and
//   ticks seen while idle are dropped until an arm beat starts a receive
module uart_frame_deframer #(
   parameter int unsigned COUNT_WIDTH = 24,
   parameter int unsigned TIMER_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ufd_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ufd_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [2:0]                          csr_index,
   input  logic [ufd_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   ufd_pkg::cfg_type         cfg;
   logic                     in_valid_ff, in_valid_in;
   ufd_pkg::req_payload_type in_payload_ff, in_payload_in;
   logic                     out_valid_ff, out_valid_in;
   ufd_pkg::rsp_payload_type out_payload_ff, out_payload_in;
   logic                     advance;
   logic                     fire;
   logic                     res_valid;
   ufd_pkg::rsp_payload_type res;

   ufd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ufd_engine #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_payload_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // output slot is free when empty or being taken this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_payload_in = in_payload_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) in_payload_in = req_payload;
      end
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      if (advance) begin
         out_valid_in = fire && res_valid;
         if (fire && res_valid) out_payload_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_payload_ff  <= in_payload_in;
      out_payload_ff <= out_payload_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

// ===== tb/uart_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module uart_frame_deframer_tb;

   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   ufd_pkg::req_payload_type            req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   ufd_pkg::rsp_payload_type            rsp_payload;
   logic                                csr_wr_en = 1'b0;
   logic [2:0]                          csr_index = '0;
   logic [ufd_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data = '0;

   uart_frame_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // stimulus and expected beats
   ufd_pkg::req_payload_type pending_items[$];
   ufd_pkg::rsp_payload_type expected_beats[$];
   int unsigned     items_queued = 0;
   int unsigned     results_seen = 0;
   int unsigned     fault_count = 0;
   int unsigned     quiet_cycles = 0;

   // predicted receiver state
   ufd_pkg::cfg_type   cfg_shadow;
   ufd_pkg::phase_type rx_phase = ufd_pkg::PH_IDLE;
   logic [19:0] tick_count = '0;
   logic [31:0] len_accum = '0;
   logic [1:0]  len_byte_sel = '0;
   logic [23:0] payload_count = '0;
   logic [7:0]  frame_cmd = '0;
   logic [15:0] head_bytes = '0;
   logic [15:0] tail_bytes = '0;
   logic [7:0]  footer_first = '0;

   // handshake pacing
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned hold_left = 0;
   int unsigned recv_calm = 0;
   logic        long_hold_done = 1'b0;

   function automatic ufd_pkg::rsp_payload_type frame_beat(ufd_pkg::kind_type k,
                                                           logic [7:0] d, logic lst,
                                                           ufd_pkg::status_type st,
                                                           logic iv);
      ufd_pkg::rsp_payload_type r;
      r.kind          = k;
      r.data          = d;
      r.last          = lst;
      r.frame_command = frame_cmd;
      r.frame_length  = (len_accum > 32'h00FF_FFFF) ? 24'hFF_FFFF : len_accum[23:0];
      r.status        = st;
      r.image_valid   = iv;
      return r;
   endfunction

   function automatic void frame_abort(ufd_pkg::status_type st);
      expected_beats.push_back(frame_beat(ufd_pkg::KIND_ERROR, 8'h00, 1'b0, st, 1'b0));
      rx_phase   = ufd_pkg::PH_IDLE;
      tick_count = '0;
   endfunction

   function automatic void deframe_step(ufd_pkg::req_payload_type item);
      logic [19:0]         limit;
      ufd_pkg::status_type st;
      logic [7:0]          b;
      logic                lst;
      logic                image_ok;
      b = item.rx_byte;
      case (item.cmd)
         ufd_pkg::CMD_ARM: begin
            len_accum     = '0;
            len_byte_sel  = '0;
            payload_count = '0;
            frame_cmd     = '0;
            head_bytes    = '0;
            tail_bytes    = '0;
            footer_first  = '0;
            rx_phase      = ufd_pkg::PH_SYNC0;
            tick_count    = '0;
         end
         ufd_pkg::CMD_TICK: begin
            if (rx_phase != ufd_pkg::PH_IDLE) begin
               case (rx_phase)
                  ufd_pkg::PH_SYNC0, ufd_pkg::PH_SYNC1: begin
                     limit = cfg_shadow.sync_timeout_ms;
                     st    = ufd_pkg::ST_SYNC_TIMEOUT;
                  end
                  ufd_pkg::PH_CMD: begin
                     limit = cfg_shadow.byte_timeout_ms;
                     st    = ufd_pkg::ST_CMD_TIMEOUT;
                  end
                  ufd_pkg::PH_LEN: begin
                     limit = cfg_shadow.byte_timeout_ms;
                     st    = ufd_pkg::ST_LEN_TIMEOUT;
                  end
                  ufd_pkg::PH_PAY: begin
                     limit = cfg_shadow.payload_idle_timeout_ms;
                     st    = ufd_pkg::ST_PAY_TIMEOUT;
                  end
                  default: begin
                     limit = cfg_shadow.byte_timeout_ms;
                     st    = ufd_pkg::ST_FOOTER_TIMEOUT;
                  end
               endcase
               if (tick_count != '1)
                  tick_count = tick_count + 1'b1;
               if (tick_count >= limit)
                  frame_abort(st);
            end
         end
         ufd_pkg::CMD_BYTE: begin
            case (rx_phase)
               ufd_pkg::PH_SYNC0: begin
                  if (b == ufd_pkg::SYNC_FIRST)
                     rx_phase = ufd_pkg::PH_SYNC1;
               end
               ufd_pkg::PH_SYNC1: begin
                  if (b == ufd_pkg::SYNC_SECOND) begin
                     rx_phase   = ufd_pkg::PH_CMD;
                     tick_count = '0;
                  end else if (b != ufd_pkg::SYNC_FIRST) begin
                     rx_phase = ufd_pkg::PH_SYNC0;
                  end
               end
               ufd_pkg::PH_CMD: begin
                  frame_cmd    = b;
                  len_accum    = '0;
                  len_byte_sel = '0;
                  rx_phase     = ufd_pkg::PH_LEN;
                  tick_count   = '0;
               end
               ufd_pkg::PH_LEN: begin
                  len_accum = len_accum | ({24'd0, b} << (8 * len_byte_sel));
                  if (len_byte_sel != 2'd3) begin
                     len_byte_sel = len_byte_sel + 1'b1;
                  end else begin
                     len_byte_sel = '0;
                     if (len_accum > {8'd0, cfg_shadow.max_payload_len}) begin
                        frame_abort(ufd_pkg::ST_TOO_LONG);
                     end else begin
                        payload_count = '0;
                        rx_phase      = (len_accum == 0) ? ufd_pkg::PH_FOOT0
                                                         : ufd_pkg::PH_PAY;
                        tick_count    = '0;
                     end
                  end
               end
               ufd_pkg::PH_PAY: begin
                  if (payload_count < 2)
                     head_bytes = {head_bytes[7:0], b};
                  tail_bytes    = {tail_bytes[7:0], b};
                  payload_count = payload_count + 1'b1;
                  tick_count    = '0;
                  lst = ({8'd0, payload_count} >= len_accum);
                  expected_beats.push_back(frame_beat(ufd_pkg::KIND_PAYLOAD, b, lst,
                                                      ufd_pkg::ST_OK, 1'b0));
                  if (lst)
                     rx_phase = ufd_pkg::PH_FOOT0;
               end
               ufd_pkg::PH_FOOT0: begin
                  footer_first = b;
                  rx_phase     = ufd_pkg::PH_FOOT1;
               end
               ufd_pkg::PH_FOOT1: begin
                  if (footer_first != ufd_pkg::FOOTER_FIRST || b != ufd_pkg::FOOTER_LAST) begin
                     frame_abort(ufd_pkg::ST_BAD_FOOTER);
                  end else begin
                     image_ok = (frame_cmd == cfg_shadow.image_command)
                             && (len_accum >= {8'd0, cfg_shadow.min_image_len})
                             && (len_accum >= 2)
                             && (head_bytes == ufd_pkg::IMAGE_SOI)
                             && (tail_bytes == ufd_pkg::IMAGE_EOI);
                     expected_beats.push_back(frame_beat(ufd_pkg::KIND_COMPLETE, 8'h00,
                                                         1'b0, ufd_pkg::ST_OK, image_ok));
                     rx_phase   = ufd_pkg::PH_IDLE;
                     tick_count = '0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic string beat_text(ufd_pkg::rsp_payload_type p);
      return $sformatf("kind=%0d data=%02h last=%0d cmd=%02h len=%06h status=%0d image=%0d",
                       p.kind, p.data, p.last, p.frame_command, p.frame_length, p.status,
                       p.image_valid);
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_item(ufd_pkg::cmd_type c, logic [7:0] b);
      ufd_pkg::req_payload_type it;
      it.cmd     = c;
      it.rx_byte = b;
      pending_items.push_back(it);
      items_queued++;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      push_item(ufd_pkg::CMD_BYTE, b);
   endfunction

   function automatic void sprinkle_ticks();
      if ($urandom_range(0, 7) == 0)
         push_item(ufd_pkg::CMD_TICK, 8'($urandom));
      if ($urandom_range(0, 39) == 0)
         push_item(ufd_pkg::CMD_NONE, 8'($urandom));
   endfunction

   // enough ticks to run out a small stage limit; a large one just sees a few
   function automatic void queue_timeout(logic [19:0] limit);
      int unsigned n;
      if (limit <= 60)
         n = limit + $urandom_range(0, 1);
      else
         n = $urandom_range(1, 4);
      repeat (n) push_item(ufd_pkg::CMD_TICK, 8'($urandom));
   endfunction

   function automatic void queue_frame();
      int unsigned stop_at, plen, i, r;
      logic [31:0] len_word;
      logic [7:0]  b;
      logic        head_mark, tail_mark;
      stop_at   = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 5) : 0;
      head_mark = ($urandom_range(0, 9) < 6);
      tail_mark = ($urandom_range(0, 9) < 6);
      push_item(ufd_pkg::CMD_ARM, 8'($urandom));
      // line noise ahead of the sync pair
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
      if ($urandom_range(0, 3) == 0)
         push_byte(ufd_pkg::SYNC_FIRST);
      sprinkle_ticks();
      if ($urandom_range(0, 14) == 0) begin
         queue_timeout(cfg_shadow.sync_timeout_ms);
         return;
      end
      push_byte(ufd_pkg::SYNC_FIRST);
      push_byte(ufd_pkg::SYNC_SECOND);
      if (stop_at == 1)
         return;
      sprinkle_ticks();
      if ($urandom_range(0, 24) == 0) begin
         queue_timeout(cfg_shadow.byte_timeout_ms);
         return;
      end
      push_byte(($urandom_range(0, 9) < 7) ? cfg_shadow.image_command : 8'($urandom));
      if (stop_at == 2)
         return;
      r = $urandom_range(0, 99);
      if (r < 78)
         len_word = $urandom_range(0, (cfg_shadow.max_payload_len < 12) ?
                                      cfg_shadow.max_payload_len : 12);
      else if (r < 88)
         len_word = cfg_shadow.max_payload_len + $urandom_range(1, 3);
      else if (r < 94)
         len_word = $urandom;
      else
         len_word = $urandom_range(0, 24);
      for (i = 0; i < 4; i++) begin
         push_byte(len_word[8*i +: 8]);
         if (i == 1 && $urandom_range(0, 24) == 0) begin
            queue_timeout(cfg_shadow.byte_timeout_ms);
            return;
         end
      end
      if (len_word > cfg_shadow.max_payload_len || stop_at == 3)
         return;
      // long payloads are cut short and dropped by the next arm
      plen = (len_word > 48) ? $urandom_range(0, 20) : len_word;
      for (i = 0; i < plen; i++) begin
         b = 8'($urandom);
         if (head_mark && i == 0)
            b = ufd_pkg::IMAGE_SOI[15:8];
         if (head_mark && i == 1)
            b = ufd_pkg::IMAGE_SOI[7:0];
         if (tail_mark && i == len_word - 2)
            b = ufd_pkg::IMAGE_EOI[15:8];
         if (tail_mark && i == len_word - 1)
            b = ufd_pkg::IMAGE_EOI[7:0];
         push_byte(b);
         if ($urandom_range(0, 39) == 0) begin
            queue_timeout(cfg_shadow.payload_idle_timeout_ms);
            return;
         end
         sprinkle_ticks();
      end
      if (plen < len_word || stop_at == 4)
         return;
      if ($urandom_range(0, 19) == 0) begin
         queue_timeout(cfg_shadow.byte_timeout_ms);
         return;
      end
      r = $urandom_range(0, 99);
      push_byte((r < 92) ? ufd_pkg::FOOTER_FIRST : 8'($urandom));
      if (stop_at == 5)
         return;
      sprinkle_ticks();
      push_byte((r < 85 || r >= 92) ? ufd_pkg::FOOTER_LAST : 8'($urandom));
   endfunction

   function automatic void fill_random(int unsigned target);
      int unsigned start;
      start = items_queued;
      while (items_queued - start < target)
         queue_frame();
   endfunction

   task automatic write_reg(ufd_pkg::reg_index_type idx, logic [23:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         ufd_pkg::REG_SYNC_TIMEOUT: cfg_shadow.sync_timeout_ms         = value[19:0];
         ufd_pkg::REG_BYTE_TIMEOUT: cfg_shadow.byte_timeout_ms         = value[19:0];
         ufd_pkg::REG_PAY_TIMEOUT:  cfg_shadow.payload_idle_timeout_ms = value[19:0];
         ufd_pkg::REG_MAX_LEN:      cfg_shadow.max_payload_len         = value;
         ufd_pkg::REG_MIN_IMAGE:    cfg_shadow.min_image_len           = value;
         ufd_pkg::REG_IMAGE_CMD:    cfg_shadow.image_command           = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_config(logic [19:0] sync_ms, logic [19:0] stage_ms,
                               logic [19:0] pay_ms, logic [23:0] max_len,
                               logic [23:0] min_len, logic [7:0] image_cmd);
      write_reg(ufd_pkg::REG_SYNC_TIMEOUT, {4'd0, sync_ms});
      write_reg(ufd_pkg::REG_BYTE_TIMEOUT, {4'd0, stage_ms});
      write_reg(ufd_pkg::REG_PAY_TIMEOUT, {4'd0, pay_ms});
      write_reg(ufd_pkg::REG_MAX_LEN, max_len);
      write_reg(ufd_pkg::REG_MIN_IMAGE, min_len);
      write_reg(ufd_pkg::REG_IMAGE_CMD, {16'd0, image_cmd});
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // waits until every item is sent and every result is out, then the pipe gets time to empty
   task automatic drain(int unsigned settle);
      while (pending_items.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         if (req_valid && !req_stall)
            deframe_step(req_payload);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (send_calm != 0) begin
                  send_calm = send_calm - 1;
               end else begin
                  send_gap = idle_length();
                  if ($urandom_range(0, 49) == 0)
                     send_calm = $urandom_range(40, 120);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall pattern, with one long hold while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         recv_calm = 0;
      end else begin
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
         end else if (!long_hold_done && results_seen > 50 && pending_items.size() > 100) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end else if (recv_calm != 0) begin
            recv_calm = recv_calm - 1;
         end else begin
            hold_left = idle_length();
            if ($urandom_range(0, 49) == 0)
               recv_calm = $urandom_range(40, 120);
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_beats.size() == 0)
            note_fault($sformatf("unexpected beat: %s", beat_text(rsp_payload)));
         else if (rsp_payload !== expected_beats[0])
            note_fault($sformatf("mismatch: expected %s, got %s",
                                 beat_text(expected_beats[0]), beat_text(rsp_payload)));
         if (expected_beats.size() != 0)
            void'(expected_beats.pop_front());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      cfg_shadow.sync_timeout_ms         = ufd_pkg::SYNC_TIMEOUT_RESET;
      cfg_shadow.byte_timeout_ms         = ufd_pkg::BYTE_TIMEOUT_RESET;
      cfg_shadow.payload_idle_timeout_ms = ufd_pkg::PAY_TIMEOUT_RESET;
      cfg_shadow.max_payload_len         = ufd_pkg::MAX_LEN_RESET;
      cfg_shadow.min_image_len           = ufd_pkg::MIN_IMAGE_RESET;
      cfg_shadow.image_command           = ufd_pkg::IMAGE_CMD_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle traffic is dropped, then a short frame, a re-arm after a sync pair, an empty frame with a bad footer
      push_item(ufd_pkg::CMD_TICK, 8'h00);
      push_byte(ufd_pkg::SYNC_FIRST);
      push_item(ufd_pkg::CMD_NONE, 8'hFF);
      push_item(ufd_pkg::CMD_ARM, 8'h00);
      push_byte(8'h12);
      push_byte(ufd_pkg::SYNC_FIRST);
      push_byte(ufd_pkg::SYNC_FIRST);
      push_byte(ufd_pkg::SYNC_SECOND);
      push_byte(ufd_pkg::IMAGE_CMD_RESET);
      push_byte(8'h04);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(ufd_pkg::IMAGE_SOI[15:8]);
      push_byte(ufd_pkg::IMAGE_SOI[7:0]);
      push_byte(ufd_pkg::IMAGE_EOI[15:8]);
      push_byte(ufd_pkg::IMAGE_EOI[7:0]);
      push_item(ufd_pkg::CMD_TICK, 8'hFF);
      push_byte(ufd_pkg::FOOTER_FIRST);
      push_byte(ufd_pkg::FOOTER_LAST);
      push_item(ufd_pkg::CMD_ARM, 8'hFF);
      push_byte(ufd_pkg::SYNC_FIRST);
      push_byte(ufd_pkg::SYNC_SECOND);
      push_item(ufd_pkg::CMD_ARM, 8'h5A);
      push_byte(ufd_pkg::SYNC_FIRST);
      push_byte(ufd_pkg::SYNC_SECOND);
      push_byte(8'h07);
      repeat (4) push_byte(8'h00);
      push_byte(ufd_pkg::FOOTER_FIRST);
      push_byte(8'h0B);
      drain(4);

      // zero limits: every tick in a stage times out, only empty frames fit
      write_config('0, '0, '0, '0, '0, '0);
      fill_random(250);
      drain(4);

      write_config(20'd40, 20'd12, 20'd6, 24'd8, 24'd2, ufd_pkg::IMAGE_CMD_RESET);
      fill_random(500);
      drain(4);

      write_config('1, '1, '1, '1, '1, 8'hFF);
      fill_random(250);
      drain(4);

      write_config(20'($urandom_range(4, 50)), 20'($urandom_range(3, 30)),
                   20'($urandom_range(2, 20)), 24'($urandom_range(0, 40)),
                   24'($urandom_range(0, 24)), 8'($urandom_range(0, 255)));
      fill_random(500);
      drain(8);

      if (expected_beats.size() != 0)
         fault_count++;
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
